/* hw/rtl/jse_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string escaper package
// Shared types, character codes and helpers for the escaper front, queue
// and back end.
// ----------------------------------------------------------------------------
package jse_pkg;

  localparam int unsigned IdxW       = 32;
  localparam int unsigned JobqDepth  = 2;
  localparam int unsigned JobqPtrW   = $clog2(JobqDepth);
  localparam int unsigned JobqCntW   = $clog2(JobqDepth + 1);
  localparam int unsigned StepW      = 3;

  // Input action codes
  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CTRL_MAX = 8'h1F;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  typedef enum logic [1:0] {
    KIND_END   = 2'd0,  // closing quote
    KIND_PASS  = 2'd1,  // byte as is
    KIND_SHORT = 2'd2,  // backslash and one escape character
    KIND_UNI   = 2'd3   // \u00 and two hex digits
  } job_kind_e;

  typedef struct packed {
    logic      action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic [IdxW-1:0] out_index;
    logic            run_last;
  } out_item_t;

  typedef struct packed {
    logic       open_quote;
    job_kind_e  kind;
    logic [7:0] ch;
  } job_t;

  // Queue side status seen by the back end
  typedef struct packed {
    logic valid;
    job_t job;
  } jobq_head_t;

  function automatic logic [StepW-1:0] body_len(input job_kind_e kind);
    logic [StepW-1:0] len;
    unique case (kind)
      KIND_END:   len = StepW'(1);
      KIND_PASS:  len = StepW'(1);
      KIND_SHORT: len = StepW'(2);
      KIND_UNI:   len = StepW'(6);
      default:    len = StepW'(1);
    endcase
    return len;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/jse_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string escaper front end
// Accepts input items, tracks the open-string state and classifies each
// byte into an expansion job for the queue.
// ----------------------------------------------------------------------------
module jse_front import jse_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire in_item_t in_item_i,
  input  wire logic     q_full_i,
  output logic          q_wr_o,
  output job_t          q_job_o
);

  logic inside_q, inside_d;
  job_t job;

  always_comb begin
    job.open_quote = ~inside_q;
    job.kind       = KIND_PASS;
    job.ch         = in_item_i.data_byte;
    if (in_item_i.action == ACT_END) begin
      job.kind = KIND_END;
      job.ch   = CH_QUOTE;
    end else begin
      unique case (in_item_i.data_byte) inside
        CH_QUOTE, CH_BSLASH: job.kind = KIND_SHORT;
        CH_BS:  begin job.kind = KIND_SHORT; job.ch = CH_LOW_B; end
        CH_FF:  begin job.kind = KIND_SHORT; job.ch = CH_LOW_F; end
        CH_LF:  begin job.kind = KIND_SHORT; job.ch = CH_LOW_N; end
        CH_CR:  begin job.kind = KIND_SHORT; job.ch = CH_LOW_R; end
        CH_TAB: begin job.kind = KIND_SHORT; job.ch = CH_LOW_T; end
        default: begin
          if (in_item_i.data_byte <= CH_CTRL_MAX) begin
            job.kind = KIND_UNI;
          end
        end
      endcase
    end
  end

  assign q_wr_o  = push_i & ~q_full_i;
  assign q_job_o = job;

  always_comb begin
    inside_d = inside_q;
    if (q_wr_o) begin
      inside_d = (in_item_i.action == ACT_DATA);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
    end else begin
      inside_q <= inside_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/jse_jobq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string escaper job queue
// Short register queue that decouples classification from expansion.
// ----------------------------------------------------------------------------
module jse_jobq import jse_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_i,
  input  wire job_t  wr_job_i,
  output logic       full_o,
  input  wire logic  rd_i,
  output jobq_head_t head_o
);

  job_t                mem_q [JobqDepth];
  logic [JobqPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [JobqPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [JobqCntW-1:0] cnt_q, cnt_d;
  logic                do_rd;

  assign full_o       = (cnt_q == JobqCntW'(JobqDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.job   = mem_q[rd_ptr_q];
  assign do_rd        = rd_i & head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == JobqPtrW'(JobqDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == JobqPtrW'(JobqDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_i && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/jse_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string escaper back end
// Expands the head job into output bytes, one per cycle unless the full
// output register waits for a pop; numbers them and holds each until popped.
// ----------------------------------------------------------------------------
module jse_back import jse_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire jobq_head_t head_i,
  output logic            q_rd_o,
  output logic            mid_job_o,
  input  wire logic       pop_i,
  output logic            empty_o,
  output out_item_t       out_item_o
);

  logic [StepW-1:0] step_q, step_d;
  logic [StepW-1:0] total_m1, body_j;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q;
  logic             load, last;
  logic [7:0]       byte_sel;
  job_t             job;

  assign job      = head_i.job;
  assign total_m1 = StepW'({{(StepW-1){1'b0}}, job.open_quote} + body_len(job.kind) - 1'b1);
  assign body_j   = step_q - {{(StepW-1){1'b0}}, job.open_quote};
  assign last     = (step_q == total_m1);
  assign load     = head_i.valid & (~out_valid_q | pop_i);
  assign q_rd_o   = load & last;

  always_comb begin
    byte_sel = CH_QUOTE;
    if (!(job.open_quote && step_q == '0)) begin
      case (job.kind)
        KIND_END:   byte_sel = CH_QUOTE;
        KIND_PASS:  byte_sel = job.ch;
        KIND_SHORT: byte_sel = (body_j == '0) ? CH_BSLASH : job.ch;
        KIND_UNI: begin
          case (body_j)
            StepW'(0): byte_sel = CH_BSLASH;
            StepW'(1): byte_sel = CH_LOW_U;
            StepW'(2): byte_sel = CH_ZERO;
            StepW'(3): byte_sel = CH_ZERO;
            StepW'(4): byte_sel = hex_digit(job.ch[7:4]);
            default:   byte_sel = hex_digit(job.ch[3:0]);
          endcase
        end
        default:    byte_sel = CH_QUOTE;
      endcase
    end
  end

  always_comb begin
    step_d      = step_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (pop_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      step_d      = last ? '0 : step_q + 1'b1;
      // hold at the top once the count saturates
      idx_d       = (idx_q == '1) ? idx_q : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_byte  <= byte_sel;
      out_q.out_index <= idx_q;
      out_q.run_last  <= last;
    end
  end

  assign empty_o    = ~out_valid_q;
  assign out_item_o = out_q;
  assign mid_job_o  = (step_q != '0);

endmodule
`default_nettype wire

/* hw/rtl/json_string_escaper.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string escaper
// Turns raw string bytes into their quoted, escaped JSON text, one output
// byte per cycle while popped, each tagged with a saturating stream position.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     push / full          in_item_i  (action, data_byte)
//  output    empty / pop          out_item_o (out_byte, out_index, run_last)
//
//  The back end emits one output byte per cycle while the output is popped,
//  so an item occupies it until all its bytes are out: 1 for a plain byte
//  inside a string, up to 7 for a control byte that opens a string. The
//  first result of an item passes through the job queue and the output
//  register before it shows on the output. A two-entry job queue lets the
//  front keep accepting while the back end expands an escape or the consumer
//  stalls. Reset needs no clearing pass; the block is ready right after it.
// ----------------------------------------------------------------------------
module json_string_escaper import jse_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item_i,
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     out_item_o
);

  logic       q_wr, q_full, q_rd, mid_job;
  job_t       q_job;
  jobq_head_t q_head;

  jse_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_item_i (in_item_i),
    .q_full_i  (q_full),
    .q_wr_o    (q_wr),
    .q_job_o   (q_job)
  );

  jse_jobq u_jobq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wr_job_i (q_job),
    .full_o   (q_full),
    .rd_i     (q_rd),
    .head_o   (q_head)
  );

  jse_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (q_head),
    .q_rd_o     (q_rd),
    .mid_job_o  (mid_job),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

  assign full = q_full;

  // A job being expanded stays at the queue head until its last byte.
  a_mid_job_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_job |-> q_head.valid)
    else $error("expansion in progress without a queued job");

  // An accepted transaction is queued for the back end on the next cycle.
  a_push_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> q_head.valid)
    else $error("accepted transaction not visible in job queue");

  // A job leaves the queue only on its final byte.
  a_rd_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd |=> !empty && out_item_o.run_last)
    else $error("job retired without a final output byte");

endmodule
`default_nettype wire
